// File: rtl/bis_pkg.sv
// Shared types and constants of the bilinear image scaler.
// Used by the top, divider, front end, back end and testbench; depends on nothing.
`timescale 1ns / 1ps

package bis_pkg;

  localparam int SRC_DIM_W  = 7;
  localparam int DST_DIM_W  = 11;
  localparam int COORD_W    = 10;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 4 * CH_W;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = SRC_DIM_W + FRAC_W;
  localparam int PROD_W     = COORD_W + STEP_W;
  localparam int POS_W      = PROD_W + 2;
  localparam int WGT_W      = 9;
  localparam int COEF_W     = 2 * WGT_W - 1;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam int MID_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH = 8;
  localparam int OUT_CNT_W   = $clog2(OUT_Q_DEPTH + 1);

  localparam logic [CFG_ADDR_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_HAS_ALPHA  = 3'd4;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic [SRC_DIM_W-1:0] SRC_DIM_MIN = 7'd2;
  localparam logic [DST_DIM_W-1:0] DST_DIM_MIN = 11'd1;
  localparam logic [WGT_W-1:0]     WGT_ONE     = 9'd256;
  localparam logic signed [POS_W-1:0] POS_HALF = 35'sd32768;

  typedef struct packed {
    logic              mode;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CH_W-1:0]   in_red;
    logic [CH_W-1:0]   in_green;
    logic [CH_W-1:0]   in_blue;
    logic [CH_W-1:0]   in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } out_item_t;

  // One classified beat: a store write, or a read of four neighbors with weights.
  typedef struct packed {
    logic               is_load;
    logic [COORD_W-1:0] col_idx;
    logic [COORD_W-1:0] row_idx;
    logic [PIX_W-1:0]   pixel;
    logic [WGT_W-1:0]   wx;
    logic [WGT_W-1:0]   wy;
  } q_entry_t;

endpackage

// File: rtl/bilinear_image_scaler_top.sv
// Bilinear image scaler. Load beats (mode 0) write one RGBA source pixel into
// an on-chip store of MAX_SRC_W x MAX_SRC_H pixels; request beats (mode 1) name
// a destination pixel and return one pixel blended from its four source
// neighbors with 9-bit weights (8 fractional bits), truncated. The store is
// split into four banks by column and row parity, so the four neighbors are
// read in the same cycle, and one beat is taken every clock while the queues
// have room and the dividers are idle. The horizontal and vertical step ratios
// come from two restoring dividers that produce one quotient bit per cycle:
// after reset and after every configuration write, full stays high while they
// settle. The store is not cleared; a request that reaches a pixel never loaded
// returns unspecified data. Depends on bis_pkg, bis_div, bis_front, bis_fifo,
// bis_back and bis_ram.
`timescale 1ns / 1ps

module bilinear_image_scaler_top #(
  parameter int MAX_SRC_W   = 64,
  parameter int MAX_SRC_H   = 64,
  parameter int MAX_DST_DIM = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  bis_pkg::in_item_t                 in_data,
  output logic                              in_full,
  input  logic                              out_pop,
  output bis_pkg::out_item_t                out_data,
  output logic                              out_empty,
  input  logic                              cfg_we,
  input  logic [bis_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [bis_pkg::SRC_DIM_W-1:0]  src_width_r;
  logic [bis_pkg::SRC_DIM_W-1:0]  src_height_r;
  logic [bis_pkg::DST_DIM_W-1:0]  dst_width_r;
  logic [bis_pkg::DST_DIM_W-1:0]  dst_height_r;
  logic                           has_alpha_r;

  logic [bis_pkg::SRC_DIM_W-1:0]  src_w;
  logic [bis_pkg::SRC_DIM_W-1:0]  src_h;
  logic [bis_pkg::DST_DIM_W-1:0]  dst_w;
  logic [bis_pkg::DST_DIM_W-1:0]  dst_h;
  logic [bis_pkg::STEP_W-1:0]     step_x;
  logic [bis_pkg::STEP_W-1:0]     step_y;
  logic                           busy_x;
  logic                           busy_y;
  logic                           div_busy;

  logic                           q_push;
  logic                           q_full;
  bis_pkg::q_entry_t              q_entry;
  logic                           q_pop;
  logic                           q_empty;
  bis_pkg::q_entry_t              q_head;

  logic                           res_push;
  bis_pkg::out_item_t             res_data;
  logic                           res_full;
  logic [bis_pkg::OUT_CNT_W-1:0]  res_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 7'd64;
      src_height_r <= 7'd64;
      dst_width_r  <= 11'd64;
      dst_height_r <= 11'd64;
      has_alpha_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bis_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[bis_pkg::SRC_DIM_W-1:0];
        bis_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[bis_pkg::SRC_DIM_W-1:0];
        bis_pkg::CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata;
        bis_pkg::CFG_DST_HEIGHT: dst_height_r <= cfg_wdata;
        bis_pkg::CFG_HAS_ALPHA:  has_alpha_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_r < bis_pkg::SRC_DIM_MIN) begin
      src_w = bis_pkg::SRC_DIM_MIN;
    end else if (32'(src_width_r) > MAX_SRC_W) begin
      src_w = bis_pkg::SRC_DIM_W'(MAX_SRC_W);
    end else begin
      src_w = src_width_r;
    end
    if (src_height_r < bis_pkg::SRC_DIM_MIN) begin
      src_h = bis_pkg::SRC_DIM_MIN;
    end else if (32'(src_height_r) > MAX_SRC_H) begin
      src_h = bis_pkg::SRC_DIM_W'(MAX_SRC_H);
    end else begin
      src_h = src_height_r;
    end
    if (dst_width_r < bis_pkg::DST_DIM_MIN) begin
      dst_w = bis_pkg::DST_DIM_MIN;
    end else if (32'(dst_width_r) > MAX_DST_DIM) begin
      dst_w = bis_pkg::DST_DIM_W'(MAX_DST_DIM);
    end else begin
      dst_w = dst_width_r;
    end
    if (dst_height_r < bis_pkg::DST_DIM_MIN) begin
      dst_h = bis_pkg::DST_DIM_MIN;
    end else if (32'(dst_height_r) > MAX_DST_DIM) begin
      dst_h = bis_pkg::DST_DIM_W'(MAX_DST_DIM);
    end else begin
      dst_h = dst_height_r;
    end
  end

  bis_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_we),
    .src_dim (src_w),
    .dst_dim (dst_w),
    .step    (step_x),
    .busy    (busy_x)
  );

  bis_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_we),
    .src_dim (src_h),
    .dst_dim (dst_h),
    .step    (step_y),
    .busy    (busy_y)
  );

  assign div_busy = busy_x || busy_y;

  bis_front #(
    .MAX_SRC_W (MAX_SRC_W),
    .MAX_SRC_H (MAX_SRC_H)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .div_busy (div_busy),
    .step_x   (step_x),
    .step_y   (step_y),
    .src_w    (src_w),
    .src_h    (src_h),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  bis_fifo #(
    .WIDTH ($bits(bis_pkg::q_entry_t)),
    .DEPTH (bis_pkg::MID_Q_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_entry),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty),
    .count ()
  );

  bis_back #(
    .MAX_SRC_W (MAX_SRC_W),
    .MAX_SRC_H (MAX_SRC_H)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .has_alpha (has_alpha_r),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  bis_fifo #(
    .WIDTH ($bits(bis_pkg::out_item_t)),
    .DEPTH (bis_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty),
    .count (res_count)
  );

  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_full)
    else $error("input taken while the step ratio is being recomputed");

  a_mid_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front end pushed a beat into a full queue");

  a_res_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result beat pushed into a full result queue");

endmodule

// File: rtl/bis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the banks of the source image store.
`timescale 1ns / 1ps

module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bis_fifo.sv
// Small register-based queue with a fill count.
// Standalone; used between front and back and as the result queue.
`timescale 1ns / 1ps

module bis_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             din,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

endmodule

// File: rtl/bis_div.sv
// Restoring divider for the Q7.16 step ratio, one quotient bit per cycle.
// Depends on bis_pkg for the size and step widths.
`timescale 1ns / 1ps

module bis_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bis_pkg::SRC_DIM_W-1:0]  src_dim,
  input  logic [bis_pkg::DST_DIM_W-1:0]  dst_dim,
  output logic [bis_pkg::STEP_W-1:0]     step,
  output logic                           busy
);

  localparam int CNT_W = $clog2(bis_pkg::STEP_W);
  localparam int REM_W = bis_pkg::DST_DIM_W;

  logic                         busy_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [REM_W-1:0]             rem_r;
  logic [bis_pkg::STEP_W-1:0]   quo_r;
  logic [bis_pkg::STEP_W-1:0]   dividend;
  logic [REM_W:0]               rem_sh;
  logic [REM_W:0]               rem_sub;
  logic                         ge;

  assign dividend = {src_dim, {bis_pkg::FRAC_W{1'b0}}};
  assign rem_sh   = {rem_r, dividend[cnt_r]};
  assign ge       = (rem_sh >= {1'b0, dst_dim});
  assign rem_sub  = rem_sh - {1'b0, dst_dim};

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(bis_pkg::STEP_W - 1);
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      quo_r <= {quo_r[bis_pkg::STEP_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign step = quo_r;
  assign busy = busy_r;

endmodule

// File: rtl/bis_front.sv
// Front end: accepts beats, maps destination coordinates to source neighbors
// and weights, and queues classified beats. Depends on bis_pkg.
`timescale 1ns / 1ps

module bis_front #(
  parameter int MAX_SRC_W = 64,
  parameter int MAX_SRC_H = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  bis_pkg::in_item_t              in_data,
  output logic                           in_full,
  input  logic                           div_busy,
  input  logic [bis_pkg::STEP_W-1:0]     step_x,
  input  logic [bis_pkg::STEP_W-1:0]     step_y,
  input  logic [bis_pkg::SRC_DIM_W-1:0]  src_w,
  input  logic [bis_pkg::SRC_DIM_W-1:0]  src_h,
  input  logic                           q_full,
  output logic                           q_push,
  output bis_pkg::q_entry_t              q_entry
);

  typedef struct packed {
    logic [bis_pkg::SRC_DIM_W-1:0] idx;
    logic [bis_pkg::WGT_W-1:0]     w;
  } axis_t;

  function automatic axis_t axis_map(input logic [bis_pkg::PROD_W-1:0]    prod,
                                     input logic [bis_pkg::STEP_W-1:0]    stp,
                                     input logic [bis_pkg::SRC_DIM_W-1:0] dim);
    logic signed [bis_pkg::POS_W-1:0] pos;
    logic signed [bis_pkg::POS_W-1:0] lim;
    axis_t                            res;
    pos = signed'(bis_pkg::POS_W'(prod)) + signed'(bis_pkg::POS_W'(stp >> 1))
          - bis_pkg::POS_HALF;
    lim = signed'(bis_pkg::POS_W'({dim - bis_pkg::SRC_DIM_W'(1),
                                    {bis_pkg::FRAC_W{1'b0}}}));
    priority if (pos[bis_pkg::POS_W-1]) begin
      res.idx = '0;
      res.w   = bis_pkg::WGT_ONE;
    end else if (pos >= lim) begin
      res.idx = dim - bis_pkg::SRC_DIM_W'(2);
      res.w   = '0;
    end else begin
      res.idx = pos[bis_pkg::FRAC_W +: bis_pkg::SRC_DIM_W];
      res.w   = bis_pkg::WGT_ONE
                - bis_pkg::WGT_W'(pos[bis_pkg::FRAC_W-bis_pkg::CH_W +: bis_pkg::CH_W]);
    end
    return res;
  endfunction

  logic                          v_a_r;
  bis_pkg::in_item_t             item_a_r;
  logic [bis_pkg::PROD_W-1:0]    prod_x_r;
  logic [bis_pkg::PROD_W-1:0]    prod_y_r;
  logic                          advance;
  logic                          accept;
  logic                          is_load;
  logic                          load_ok;
  axis_t                         ax;
  axis_t                         ay;

  assign advance = !v_a_r || !q_full;
  assign in_full = div_busy || !advance;
  assign accept  = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (advance) begin
      v_a_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      item_a_r <= in_data;
      prod_x_r <= bis_pkg::PROD_W'(in_data.col) * bis_pkg::PROD_W'(step_x);
      prod_y_r <= bis_pkg::PROD_W'(in_data.row) * bis_pkg::PROD_W'(step_y);
    end
  end

  assign ax      = axis_map(prod_x_r, step_x, src_w);
  assign ay      = axis_map(prod_y_r, step_y, src_h);
  assign is_load = (item_a_r.mode == bis_pkg::MODE_LOAD);
  assign load_ok = (32'(item_a_r.col) < MAX_SRC_W) && (32'(item_a_r.row) < MAX_SRC_H);
  assign q_push  = v_a_r && !q_full && (!is_load || load_ok);

  always_comb begin
    q_entry.is_load = is_load;
    q_entry.pixel   = {item_a_r.in_alpha, item_a_r.in_blue,
                       item_a_r.in_green, item_a_r.in_red};
    q_entry.wx      = ax.w;
    q_entry.wy      = ay.w;
    if (is_load) begin
      q_entry.col_idx = item_a_r.col;
      q_entry.row_idx = item_a_r.row;
    end else begin
      q_entry.col_idx = bis_pkg::COORD_W'(ax.idx);
      q_entry.row_idx = bis_pkg::COORD_W'(ay.idx);
    end
  end

endmodule

// File: rtl/bis_back.sv
// Back end: writes source pixels into four parity banks, reads the four
// neighbors in the same cycle and blends them. Depends on bis_pkg and bis_ram.
`timescale 1ns / 1ps

module bis_back #(
  parameter int MAX_SRC_W = 64,
  parameter int MAX_SRC_H = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  bis_pkg::q_entry_t               q_head,
  output logic                            q_pop,
  input  logic                            has_alpha,
  input  logic [bis_pkg::OUT_CNT_W-1:0]   res_count,
  output logic                            res_push,
  output bis_pkg::out_item_t              res_data
);

  localparam int HALF_W     = (MAX_SRC_W + 1) / 2;
  localparam int HALF_H     = (MAX_SRC_H + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int MUL_W      = bis_pkg::CH_W + bis_pkg::COEF_W;
  localparam int SUM_W      = MUL_W + 2;

  logic                           credit_ok;
  logic                           issue_rd;
  logic [bis_pkg::COORD_W-1:0]    col_h;
  logic [bis_pkg::COORD_W-1:0]    row_h;
  logic [bis_pkg::WGT_W-1:0]      wxc;
  logic [bis_pkg::WGT_W-1:0]      wyc;
  logic [2*bis_pkg::WGT_W-1:0]    cprod [4];
  logic [bis_pkg::PIX_W-1:0]      bank_rd [4];
  logic [bis_pkg::PIX_W-1:0]      pix_sel [4];
  logic [SUM_W-1:0]               sum [4];

  logic                           v_r;
  logic                           sx_r;
  logic                           sy_r;
  logic [bis_pkg::COEF_W-1:0]     coef_r [4];
  logic                           v_m;
  logic [MUL_W-1:0]               prod_r [4][4];

  assign credit_ok = (32'(res_count) + 32'(v_r) + 32'(v_m)) < bis_pkg::OUT_Q_DEPTH;
  assign q_pop     = !q_empty && (q_head.is_load || credit_ok);
  assign issue_rd  = q_pop && !q_head.is_load;
  assign col_h     = q_head.col_idx >> 1;
  assign row_h     = q_head.row_idx >> 1;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PC = 1'(b % 2);
    localparam logic PR = 1'(b / 2);
    logic [bis_pkg::COORD_W-1:0] ch_b;
    logic [bis_pkg::COORD_W-1:0] rh_b;
    logic [BAW-1:0]              addr_b;
    logic                        we_b;

    // An odd left index puts its right neighbor in the next even-bank slot.
    assign ch_b   = col_h + bis_pkg::COORD_W'(q_head.col_idx[0] & ~PC);
    assign rh_b   = row_h + bis_pkg::COORD_W'(q_head.row_idx[0] & ~PR);
    assign addr_b = BAW'(32'(rh_b) * HALF_W + 32'(ch_b));
    assign we_b   = q_pop && q_head.is_load &&
                    (q_head.row_idx[0] == PR) && (q_head.col_idx[0] == PC);

    bis_ram #(
      .WIDTH (bis_pkg::PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (we_b),
      .waddr (addr_b),
      .wdata (q_head.pixel),
      .re    (issue_rd),
      .raddr (addr_b),
      .rdata (bank_rd[b])
    );
  end

  always_comb begin
    wxc      = bis_pkg::WGT_ONE - q_head.wx;
    wyc      = bis_pkg::WGT_ONE - q_head.wy;
    cprod[0] = (2*bis_pkg::WGT_W)'(q_head.wx) * (2*bis_pkg::WGT_W)'(q_head.wy);
    cprod[1] = (2*bis_pkg::WGT_W)'(wxc) * (2*bis_pkg::WGT_W)'(q_head.wy);
    cprod[2] = (2*bis_pkg::WGT_W)'(q_head.wx) * (2*bis_pkg::WGT_W)'(wyc);
    cprod[3] = (2*bis_pkg::WGT_W)'(wxc) * (2*bis_pkg::WGT_W)'(wyc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      v_m <= 1'b0;
    end else begin
      v_r <= issue_rd;
      v_m <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    sx_r <= q_head.col_idx[0];
    sy_r <= q_head.row_idx[0];
    for (int k = 0; k < 4; k++) begin
      coef_r[k] <= cprod[k][bis_pkg::COEF_W-1:0];
    end
  end

  // Neighbor k sits in the bank whose parities are the left/top parities
  // flipped by the neighbor's offsets.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pix_sel[k] = bank_rd[{sy_r ^ k[1], sx_r ^ k[0]}];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[c][k] <= MUL_W'(pix_sel[k][c*bis_pkg::CH_W +: bis_pkg::CH_W])
                        * MUL_W'(coef_r[k]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1])
               + SUM_W'(prod_r[c][2]) + SUM_W'(prod_r[c][3]);
    end
    res_data.out_red   = sum[0][2*bis_pkg::CH_W +: bis_pkg::CH_W];
    res_data.out_green = sum[1][2*bis_pkg::CH_W +: bis_pkg::CH_W];
    res_data.out_blue  = sum[2][2*bis_pkg::CH_W +: bis_pkg::CH_W];
    res_data.out_alpha = has_alpha ? sum[3][2*bis_pkg::CH_W +: bis_pkg::CH_W] : '0;
  end

  assign res_push = v_m;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (32'(res_count) < bis_pkg::OUT_Q_DEPTH))
    else $error("result produced with no room in the result queue");

endmodule

// File: dv/bilinear_image_scaler_top_tb.sv
// Self-checking testbench for bilinear_image_scaler_top: a directed table, then random
// phases of loads and requests under changing scale settings, checked against values
// from the table or an in-bench predictor. Depends on bis_pkg and the scaler RTL.
`timescale 1ns / 1ps

module bilinear_image_scaler_top_tb;
  import bis_pkg::*;

  localparam int MAX_SRC_W   = 64;
  localparam int MAX_SRC_H   = 64;
  localparam int MAX_DST_DIM = 1024;
  localparam int ITEM_TARGET = 1550;
  localparam int DRAIN_TAIL  = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int HALF_PIXEL  = 1 << (FRAC_W - 1);

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = CFG_HAS_ALPHA + 1'b1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = '1;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_PERIODIC} pop_mode_e;

  typedef struct {
    row_kind_e                 kind;
    in_item_t                  beat;
    logic [CFG_ADDR_W-1:0]     addr;
    logic [CFG_DATA_W-1:0]     wdata;
    bit                        typed;
    out_item_t                 want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_full;
  logic                  out_pop   = 1'b0;
  out_item_t             out_data;
  logic                  out_empty;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [PIX_W-1:0]      src_pix [MAX_SRC_W*MAX_SRC_H];
  bit                    pix_loaded [MAX_SRC_W*MAX_SRC_H];
  logic [SRC_DIM_W-1:0]  src_w_reg = 7'd64;
  logic [SRC_DIM_W-1:0]  src_h_reg = 7'd64;
  logic [DST_DIM_W-1:0]  dst_w_reg = 11'd64;
  logic [DST_DIM_W-1:0]  dst_h_reg = 11'd64;
  logic                  alpha_en  = 1'b0;
  out_item_t             expected_pixels [$];

  dir_row_t              script [$];
  int                    errors     = 0;
  int                    items_done = 0;
  int                    burst_left = 0;
  bit                    no_gap     = 0;
  bit                    cfg_open   = 0;
  int                    stall_cycles = 0;
  int                    pop_left   = 0;
  pop_mode_e             pop_mode   = POP_ALWAYS;

  logic [3:0][CH_W-1:0]  want_ch, got_ch;
  string                 chan_name [4] = '{"out_alpha", "out_blue", "out_green", "out_red"};

  bilinear_image_scaler_top #(
    .MAX_SRC_W  (MAX_SRC_W),
    .MAX_SRC_H  (MAX_SRC_H),
    .MAX_DST_DIM(MAX_DST_DIM)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_data (out_data),
    .out_empty(out_empty),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Left/top neighbor index and its weight along one axis.
  function automatic void locate_axis(input int unsigned d, input int unsigned s,
                                      input int unsigned n, output int unsigned idx,
                                      output int unsigned wgt);
    longint step, pos;
    step = (longint'(s) << FRAC_W) / longint'(n);
    pos  = longint'(d) * step + (step >>> 1) - HALF_PIXEL;
    if (pos < 0) begin
      idx = 0;
      wgt = WGT_ONE;
    end else if (pos >= (longint'(s - 1) << FRAC_W)) begin
      idx = s - 2;
      wgt = 0;
    end else begin
      idx = int'(pos >>> FRAC_W);
      wgt = WGT_ONE - int'((pos >>> (FRAC_W - CH_W)) & 255);
    end
  endfunction

  function automatic void source_cell(input int unsigned col, input int unsigned row,
                                      output int unsigned ix, output int unsigned wx,
                                      output int unsigned iy, output int unsigned wy);
    locate_axis(col, clamp_dim(src_w_reg, SRC_DIM_MIN, MAX_SRC_W),
                clamp_dim(dst_w_reg, DST_DIM_MIN, MAX_DST_DIM), ix, wx);
    locate_axis(row, clamp_dim(src_h_reg, SRC_DIM_MIN, MAX_SRC_H),
                clamp_dim(dst_h_reg, DST_DIM_MIN, MAX_DST_DIM), iy, wy);
  endfunction

  function automatic out_item_t bilinear_pixel(int unsigned col, int unsigned row);
    int unsigned ix, wx, iy, wy, sum;
    int unsigned wt [4];
    logic [PIX_W-1:0] nb [4];
    logic [PIX_W-1:0] acc;
    out_item_t px;
    source_cell(col, row, ix, wx, iy, wy);
    nb[0] = src_pix[iy * MAX_SRC_W + ix];
    nb[1] = src_pix[iy * MAX_SRC_W + ix + 1];
    nb[2] = src_pix[(iy + 1) * MAX_SRC_W + ix];
    nb[3] = src_pix[(iy + 1) * MAX_SRC_W + ix + 1];
    wt[0] = wx * wy;
    wt[1] = (WGT_ONE - wx) * wy;
    wt[2] = wx * (WGT_ONE - wy);
    wt[3] = (WGT_ONE - wx) * (WGT_ONE - wy);
    for (int ch = 0; ch < 4; ch++) begin
      sum = 0;
      for (int k = 0; k < 4; k++) sum += nb[k][CH_W*ch +: CH_W] * wt[k];
      acc[CH_W*ch +: CH_W] = sum >> FRAC_W;
    end
    px = out_item_t'(acc);
    if (!alpha_en) px.out_alpha = '0;
    return px;
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_load(int unsigned col, int unsigned row);
    in_item_t it;
    it.mode     = MODE_LOAD;
    it.col      = COORD_W'(col);
    it.row      = COORD_W'(row);
    it.in_red   = rand_chan();
    it.in_green = rand_chan();
    it.in_blue  = rand_chan();
    it.in_alpha = rand_chan();
    return it;
  endfunction

  function automatic dir_row_t load_row(int unsigned col, int unsigned row, logic [31:0] rgba);
    dir_row_t r;
    r = '{ROW_BEAT, in_item_t'({MODE_LOAD, COORD_W'(col), COORD_W'(row), rgba}),
          '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t req_row(int unsigned col, int unsigned row);
    dir_row_t r;
    r = '{ROW_BEAT, in_item_t'({MODE_REQUEST, COORD_W'(col), COORD_W'(row), 32'h0}),
          '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t check_row(int unsigned col, int unsigned row, logic [31:0] rgba);
    dir_row_t r;
    r = req_row(col, row);
    r.typed = 1'b1;
    r.want  = out_item_t'(rgba);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    dir_row_t r;
    r = '{ROW_CFG, '0, a, d, 1'b0, '0};
    return r;
  endfunction

  task automatic idle_for(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_for(1);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    if (!cfg_open) drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_open = 1;
    case (a)
      CFG_SRC_WIDTH:  src_w_reg = d[SRC_DIM_W-1:0];
      CFG_SRC_HEIGHT: src_h_reg = d[SRC_DIM_W-1:0];
      CFG_DST_WIDTH:  dst_w_reg = d[DST_DIM_W-1:0];
      CFG_DST_HEIGHT: dst_h_reg = d[DST_DIM_W-1:0];
      CFG_HAS_ALPHA:  alpha_en  = d[0];
      default: ;
    endcase
  endtask

  task automatic push_beat(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    if (cfg_open) begin
      cfg_we <= 1'b0;
      @(posedge clk);
      cfg_open = 0;
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    if (it.mode == MODE_LOAD) begin
      if (it.col < MAX_SRC_W && it.row < MAX_SRC_H) begin
        src_pix[it.row * MAX_SRC_W + it.col] = {it.in_red, it.in_green, it.in_blue, it.in_alpha};
        pix_loaded[it.row * MAX_SRC_W + it.col] = 1'b1;
        items_done++;
      end
    end else begin
      expected_pixels.push_back(typed ? want : bilinear_pixel(it.col, it.row));
      items_done++;
    end
  endtask

  task automatic pace();
    if (no_gap) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_for($urandom_range(1, 6));
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // A request is preceded by loads of any of its four neighbors still unwritten.
  task automatic random_request();
    int unsigned ix, wx, iy, wy, col, row, a;
    in_item_t it;
    col = ($urandom_range(0, 9) < 7) ?
          $urandom_range(0, clamp_dim(dst_w_reg, DST_DIM_MIN, MAX_DST_DIM) - 1) :
          $urandom_range(0, COORD_MAX);
    row = ($urandom_range(0, 9) < 7) ?
          $urandom_range(0, clamp_dim(dst_h_reg, DST_DIM_MIN, MAX_DST_DIM) - 1) :
          $urandom_range(0, COORD_MAX);
    source_cell(col, row, ix, wx, iy, wy);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        a = (iy + dy) * MAX_SRC_W + ix + dx;
        if (!pix_loaded[a]) begin
          push_beat(make_load(ix + dx, iy + dy));
          pace();
        end
      end
    end
    it = make_load(col, row);
    it.mode = MODE_REQUEST;
    push_beat(it);
    pace();
  endtask

  task automatic random_action();
    int unsigned pick, sw, sh;
    pick = $urandom_range(0, 99);
    sw = clamp_dim(src_w_reg, SRC_DIM_MIN, MAX_SRC_W);
    sh = clamp_dim(src_h_reg, SRC_DIM_MIN, MAX_SRC_H);
    if (pick < 55) begin
      random_request();
    end else if (pick < 90) begin
      if ($urandom_range(0, 3) != 0)
        push_beat(make_load($urandom_range(0, sw - 1), $urandom_range(0, sh - 1)));
      else
        push_beat(make_load($urandom_range(0, MAX_SRC_W - 1), $urandom_range(0, MAX_SRC_H - 1)));
      pace();
    end else begin
      if ($urandom_range(0, 1) != 0)
        push_beat(make_load($urandom_range(MAX_SRC_W, COORD_MAX), $urandom_range(0, COORD_MAX)));
      else
        push_beat(make_load($urandom_range(0, COORD_MAX), $urandom_range(MAX_SRC_H, COORD_MAX)));
      pace();
    end
  endtask

  function automatic logic [SRC_DIM_W-1:0] rand_src_dim();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return SRC_DIM_W'($urandom_range(2, 8));
      6: return SRC_DIM_W'(MAX_SRC_W);
      7: return SRC_DIM_W'($urandom_range(9, MAX_SRC_W - 1));
      8: return SRC_DIM_W'($urandom_range(0, 1));
      default: return SRC_DIM_W'($urandom_range(MAX_SRC_W + 1, (1 << SRC_DIM_W) - 1));
    endcase
  endfunction

  function automatic logic [DST_DIM_W-1:0] rand_dst_dim();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return DST_DIM_W'($urandom_range(1, 16));
      5: return DST_DIM_W'($urandom_range(17, MAX_DST_DIM - 1));
      6: return DST_DIM_W'(MAX_DST_DIM);
      7: return DST_DIM_W'(1);
      8: return '0;
      default: return DST_DIM_W'($urandom_range(MAX_DST_DIM + 1, (1 << DST_DIM_W) - 1));
    endcase
  endfunction

  task automatic choose_setting(int phase);
    logic [SRC_DIM_W-1:0] sw, sh;
    logic [DST_DIM_W-1:0] dw, dh;
    logic al;
    case (phase)
      0: begin sw = 7'd64;  sh = 7'd64;  dw = 11'd1024; dh = 11'd1024; al = 1'b1; end
      1: begin sw = 7'd2;   sh = 7'd2;   dw = 11'd1;    dh = 11'd1;    al = 1'b0; end
      2: begin sw = 7'd64;  sh = 7'd2;   dw = 11'd2047; dh = 11'd0;    al = 1'b1; end
      3: begin sw = 7'd0;   sh = 7'd127; dw = 11'd1;    dh = 11'd1024; al = 1'b0; end
      default: begin
        sw = rand_src_dim();
        sh = rand_src_dim();
        dw = rand_dst_dim();
        dh = rand_dst_dim();
        al = 1'($urandom);
      end
    endcase
    cfg_write(CFG_SRC_WIDTH,  {(CFG_DATA_W - SRC_DIM_W)'($urandom), sw});
    cfg_write(CFG_SRC_HEIGHT, {(CFG_DATA_W - SRC_DIM_W)'($urandom), sh});
    cfg_write(CFG_DST_WIDTH,  dw);
    cfg_write(CFG_DST_HEIGHT, dh);
    cfg_write(CFG_HAS_ALPHA,  {(CFG_DATA_W - 1)'($urandom), al});
    if ($urandom_range(0, 3) == 0)
      cfg_write(CFG_SPARE_LO + CFG_ADDR_W'($urandom_range(0, CFG_SPARE_HI - CFG_SPARE_LO)),
                CFG_DATA_W'($urandom));
  endtask

  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_mode <= pop_mode_e'($urandom_range(0, 3));
      pop_left <= $urandom_range(10, 200);
    end else begin
      pop_left <= pop_left - 1;
    end
    case (pop_mode)
      POP_ALWAYS: out_pop <= 1'b1;
      POP_MOSTLY: out_pop <= ($urandom_range(0, 3) != 0);
      POP_RARELY: out_pop <= ($urandom_range(0, 3) == 0);
      default:    out_pop <= (pop_left % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want_ch = expected_pixels.pop_front();
        got_ch  = out_data;
        for (int i = 0; i < 4; i++) begin
          if (want_ch[i] !== got_ch[i]) begin
            $display("%0t: %s expected %h got %h", $time, chan_name[i], want_ch[i], got_ch[i]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("** bilinear_image_scaler_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase;
    script = '{
      load_row(0, 0, 32'hff00807f),
      load_row(1, 0, 32'h00ff7f80),
      load_row(0, 1, 32'h12345678),
      load_row(1, 1, 32'habcdef01),
      load_row(62, 62, 32'h0f1e2d3c),
      load_row(63, 62, 32'hc3d2e1f0),
      load_row(62, 63, 32'h01020304),
      load_row(63, 63, 32'h55aa01fe),
      check_row(0, 0, 32'hff008000),
      check_row(63, 63, 32'h55aa0100),
      check_row(COORD_MAX, COORD_MAX, 32'h55aa0100),
      load_row(MAX_SRC_W, 0, 32'h11223344),
      load_row(0, MAX_SRC_H, 32'h99887766),
      check_row(0, 0, 32'hff008000),
      cfg_row(CFG_HAS_ALPHA, 11'd1),
      check_row(0, 0, 32'hff00807f),
      check_row(63, 62, 32'hc3d2e1f0),
      cfg_row(CFG_SRC_WIDTH, 11'd0),
      cfg_row(CFG_SRC_HEIGHT, 11'd1),
      cfg_row(CFG_DST_WIDTH, 11'd0),
      cfg_row(CFG_DST_HEIGHT, 11'd0),
      req_row(0, 0),
      req_row(COORD_MAX, 0),
      cfg_row(CFG_SRC_WIDTH, 11'h0ff),
      cfg_row(CFG_SRC_HEIGHT, 11'd127),
      cfg_row(CFG_DST_WIDTH, 11'd2047),
      cfg_row(CFG_DST_HEIGHT, 11'd1024),
      req_row(0, 0),
      req_row(COORD_MAX, COORD_MAX),
      req_row(1, 1),
      cfg_row(CFG_SPARE_LO, 11'h000),
      cfg_row(CFG_SPARE_HI, 11'h7ff),
      req_row(COORD_MAX, COORD_MAX),
      req_row(0, 0)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        cfg_write(script[i].addr, script[i].wdata);
      end else begin
        push_beat(script[i].beat, script[i].typed, script[i].want);
        pace();
      end
    end

    phase = 0;
    while (items_done < ITEM_TARGET) begin
      choose_setting(phase);
      no_gap = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 120)) random_action();
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("** bilinear_image_scaler_top: PASSED **");
    end else begin
      $display("** bilinear_image_scaler_top: FAILED **");
    end
    $finish;
  end

endmodule
